FILE: hdl/wtss_pkg.sv
`timescale 1ns / 1ps
// Package for the weekly time switch schedule core.
// Holds sizes, word types, the controller state type and the id_trim helper; no dependencies.
package wtss_pkg;

  localparam int NUM_SLOTS      = 64;
  localparam int OUTPUT_ID_BITS = 10;
  localparam int SLOT_BITS      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int TIME_BITS   = 17;
  localparam int ACTION_BITS = 8;
  localparam int DAY_BITS    = 7;
  localparam int ID_IN_BITS  = 10;
  localparam int WDAY_BITS   = 3;
  localparam int ESLOT_BITS  = 6;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [ESLOT_BITS-1:0]  entry_slot;
    logic [TIME_BITS-1:0]   entry_time;
    logic [ACTION_BITS-1:0] entry_action;
    logic [ID_IN_BITS-1:0]  entry_output;
    logic [DAY_BITS-1:0]    entry_days;
    logic [TIME_BITS-1:0]   now_seconds;
    logic [WDAY_BITS-1:0]   weekday;
    logic [ID_IN_BITS-1:0]  query_output;
  } in_word_t;

  typedef struct packed {
    logic                   matched;
    logic [ACTION_BITS-1:0] state_value;
    logic                   from_today;
  } out_word_t;

  // One table entry as kept in the slot memory
  typedef struct packed {
    logic [TIME_BITS-1:0]      sw_time;
    logic [ACTION_BITS-1:0]    action;
    logic [OUTPUT_ID_BITS-1:0] out_id;
    logic [DAY_BITS-1:0]       days;
  } slot_word_t;

  localparam int SLOT_WORD_BITS = $bits(slot_word_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  // Output ids are compared in their low OUTPUT_ID_BITS bits
  function automatic logic [OUTPUT_ID_BITS-1:0] id_trim(input logic [ID_IN_BITS-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    return e[OUTPUT_ID_BITS-1:0];
  endfunction

endpackage

FILE: hdl/wtss_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module wtss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/weekly_time_switch_schedule_core.sv
`timescale 1ns / 1ps
// Weekly time switch schedule: slot memory, valid bits, scan controller.
// Depends on wtss_pkg and wtss_ram.
//
//  channel  | handshake           | word
//  ---------+---------------------+-----------------------------------
//  in       | in_valid / in_ready | in_data  (load slot or query output)
//  out      | out_valid/out_ready | out_data (matched, state, from_today)
//
// A load is accepted and written, then its result is registered.
// A query makes one memory read per slot, then waits in S_DRAIN for the
// last read data, then registers the result.
// Reset clears the valid bits at once; the slot memory needs no clearing.
// A word is accepted whenever the controller is idle, even while an earlier
// result is still held; only the final step waits for out_ready.
module weekly_time_switch_schedule_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wtss_pkg::in_word_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wtss_pkg::out_word_t out_data
);

  import wtss_pkg::*;

  state_t state_r, state_nxt;

  logic [NUM_SLOTS-1:0] slot_valid_r;
  logic [SLOT_BITS-1:0] scan_cnt_r;
  logic                 pend_r, pend_valid_r;

  logic [TIME_BITS-1:0]      q_now_r;
  logic [WDAY_BITS-1:0]      q_wday_r;
  logic [OUTPUT_ID_BITS-1:0] q_out_r;

  logic                   any_hit_r, today_hit_r;
  logic [ACTION_BITS-1:0] any_act_r, today_act_r;

  logic      out_valid_r;
  out_word_t out_data_r;

  logic       in_fire, load_ok, scan_last, fin_go, scan_en;
  logic [31:0] slot_ext;
  logic [SLOT_BITS-1:0] wr_addr;
  slot_word_t wr_word, rd_word;
  logic [SLOT_WORD_BITS-1:0] rd_raw;
  logic [DAY_BITS:0] days_ext;
  logic       id_hit, day_hit;
  out_word_t  res;

  assign in_fire   = in_valid && in_ready;
  assign slot_ext  = 32'(in_data.entry_slot);
  assign load_ok   = slot_ext < NUM_SLOTS;
  assign wr_addr   = slot_ext[SLOT_BITS-1:0];
  assign scan_last = scan_cnt_r == SLOT_BITS'(NUM_SLOTS - 1);

  assign wr_word.sw_time = in_data.entry_time;
  assign wr_word.action  = in_data.entry_action;
  assign wr_word.out_id  = id_trim(in_data.entry_output);
  assign wr_word.days    = in_data.entry_days;

  wtss_ram #(
    .WIDTH (SLOT_WORD_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (in_fire && in_data.mode == MODE_LOAD && load_ok),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (scan_en),
    .rd_addr (scan_cnt_r),
    .rd_data (rd_raw)
  );

  assign rd_word = slot_word_t'(rd_raw);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_data.mode == MODE_QUERY) ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_FIN;
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready = 1'b0;
    scan_en  = 1'b0;
    fin_go   = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_SCAN:  scan_en  = 1'b1;
      S_DRAIN: ;
      S_FIN:   fin_go   = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (in_fire && in_data.mode == MODE_LOAD && load_ok) begin
      slot_valid_r[wr_addr] <= 1'b1;
    end
  end

  // Scan address and read pipeline tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      pend_r <= scan_en;
      if (in_fire) begin
        scan_cnt_r <= '0;
      end else if (scan_en) begin
        scan_cnt_r <= scan_cnt_r + SLOT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_valid_r <= slot_valid_r[scan_cnt_r];
    if (in_fire) begin
      q_now_r  <= in_data.now_seconds;
      q_wday_r <= in_data.weekday;
      q_out_r  <= id_trim(in_data.query_output);
    end
  end

  // Weekday 7 selects the padding zero, so nothing fires today
  assign days_ext = {1'b0, rd_word.days};
  assign day_hit  = days_ext[q_wday_r];
  assign id_hit   = pend_r && pend_valid_r && rd_word.out_id == q_out_r;

  // Later slots override earlier ones
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_hit_r   <= 1'b0;
      today_hit_r <= 1'b0;
    end else if (in_fire) begin
      any_hit_r   <= 1'b0;
      today_hit_r <= 1'b0;
    end else if (id_hit) begin
      any_hit_r <= 1'b1;
      if (day_hit && rd_word.sw_time <= q_now_r) begin
        today_hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (id_hit) begin
      any_act_r <= rd_word.action;
      if (day_hit && rd_word.sw_time <= q_now_r) begin
        today_act_r <= rd_word.action;
      end
    end
  end

  always_comb begin
    res.matched    = any_hit_r || today_hit_r;
    res.from_today = today_hit_r;
    if (today_hit_r) begin
      res.state_value = today_act_r;
    end else if (any_hit_r) begin
      res.state_value = any_act_r;
    end else begin
      res.state_value = '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_today_implies_any: assert property (@(posedge clk) disable iff (!rst_n)
    today_hit_r |-> any_hit_r)
    else $error("today hit without any-day hit");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.mode == MODE_LOAD && load_ok) |=> slot_valid_r[$past(wr_addr)])
    else $error("loaded slot not marked valid");

  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.matched) |-> (out_data.state_value == '0 && !out_data.from_today))
    else $error("unmatched result carries data");

  a_scan_ends_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_last) |=> (state_r == S_DRAIN && pend_r))
    else $error("scan did not end with last read pending");

  a_no_read_outside_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !scan_en)
    else $error("memory read outside scan");

endmodule
